>>> rtl/clwf_pkg.sv
// ----------------------------------------------------------------------------
// clwf_pkg: shared types and constants
// Node count, link and index widths, opcodes, status codes, payload and node
// store request structs, the sequencer state type and link helpers of the unit.
// ----------------------------------------------------------------------------
package clwf_pkg;

    localparam int NODES   = 8;
    localparam int IDX_W   = $clog2(NODES);
    localparam int LINK_W  = $clog2(NODES + 1);
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 3;

    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NODES);
    localparam logic [IDX_W-1:0]  LAST_STEP = IDX_W'(NODES - 1);

    typedef enum logic [1:0] {
        F_INS_HEAD = 2'd0,
        F_INS_TAIL = 2'd1,
        F_DEL_HEAD = 2'd2,
        F_DEL_TAIL = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]              func;
        logic signed [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } t_out;

    // one node store access per cycle: a link read, a link write and an
    // optional element write at the link write index
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_idx;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_idx;
        logic [LINK_W-1:0] wr_link;
        logic              val_en;
        logic [VAL_W-1:0]  val_data;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WALK,
        S_DH,
        S_DT_FIRST,
        S_DT_WALK,
        S_DT_FREE,
        S_FIN
    } t_state;

    function automatic logic is_node(input logic [LINK_W-1:0] l);
        return l < LINK_NULL;
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [LINK_W-1:0] l);
        return l[IDX_W-1:0];
    endfunction

    // link value of an entry never written since reset
    function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] ix);
        logic [LINK_W-1:0] wide;
        wide = {{(LINK_W - IDX_W){1'b0}}, ix};
        return (ix == '0) ? LINK_NULL : wide - LINK_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(input logic [LINK_W-1:0] l);
        logic [LINK_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, l};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

>>> rtl/clwf_node_ram.sv
// ----------------------------------------------------------------------------
// clwf_node_ram: node store
// Link and element arrays with a registered link read. Per-entry valid
// flops make unwritten links read as their reset value.
// ----------------------------------------------------------------------------
module clwf_node_ram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  clwf_pkg::t_mem_req         i_req,
    output logic [clwf_pkg::LINK_W-1:0] o_rd_link
);
    import clwf_pkg::*;

    logic [LINK_W-1:0] r_link_mem [NODES];
    logic [VAL_W-1:0]  r_val_mem  [NODES];
    logic [NODES-1:0]  r_written;
    logic [LINK_W-1:0] r_q;
    logic              r_q_hit;
    logic [IDX_W-1:0]  r_q_idx;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_link_mem[i_req.wr_idx] <= i_req.wr_link;
        end
        if (i_req.wr_en && i_req.val_en) begin
            r_val_mem[i_req.wr_idx] <= i_req.val_data;
        end
        if (i_req.rd_en) begin
            r_q     <= r_link_mem[i_req.rd_idx];
            r_q_idx <= i_req.rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_q_hit   <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_idx] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_q_hit <= r_written[i_req.rd_idx];
            end
        end
    end

    assign o_rd_link = r_q_hit ? r_q : reset_link(r_q_idx);

endmodule

>>> rtl/clwf_seq.sv
// ----------------------------------------------------------------------------
// clwf_seq: request sequencer
// Holds the list and free heads, walks links one per cycle through the
// node store, and registers the result for the output channel.
// ----------------------------------------------------------------------------
module clwf_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  clwf_pkg::t_in               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output clwf_pkg::t_out              o_out,
    output clwf_pkg::t_mem_req          o_req,
    input  logic [clwf_pkg::LINK_W-1:0] i_rd_link
);
    import clwf_pkg::*;

    t_state            r_state, n_state;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_free, n_free;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_slot, n_slot;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    t_func             r_func, n_func;
    logic [VAL_W-1:0]  r_val, n_val;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_out              r_out, n_out;
    logic              accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= LINK_NULL;
            r_free      <= LINK_W'(NODES - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_slot   <= n_slot;
        r_cnt    <= n_cnt;
        r_func   <= n_func;
        r_val    <= n_val;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_free      = r_free;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_func      = r_func;
        n_val       = r_val;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_req       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func   = t_func'(i_in.func);
                    n_val    = i_in.value;
                    n_status = ST_DONE;
                    unique case (t_func'(i_in.func))
                        F_INS_HEAD, F_INS_TAIL: begin
                            if (!is_node(r_free)) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end else begin
                                n_slot       = r_free;
                                o_req.rd_en  = 1'b1;
                                o_req.rd_idx = to_idx(r_free);
                                n_state      = S_INS_RD;
                            end
                        end
                        F_DEL_HEAD, F_DEL_TAIL: begin
                            if (!is_node(r_head)) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_slot       = r_head;
                                o_req.rd_en  = 1'b1;
                                o_req.rd_idx = to_idx(r_head);
                                n_state = (t_func'(i_in.func) == F_DEL_HEAD) ? S_DH
                                                                             : S_DT_FIRST;
                            end
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                // i_rd_link is the link of the node taken from the pool
                n_free         = i_rd_link;
                o_req.wr_en    = 1'b1;
                o_req.wr_idx   = to_idx(r_slot);
                o_req.val_en   = 1'b1;
                o_req.val_data = r_val;
                if (r_func == F_INS_HEAD || !is_node(r_head)) begin
                    o_req.wr_link = (r_func == F_INS_HEAD) ? r_head : LINK_NULL;
                    n_head        = r_slot;
                    n_state       = S_FIN;
                end else begin
                    o_req.wr_link = LINK_NULL;
                    o_req.rd_en   = 1'b1;
                    o_req.rd_idx  = to_idx(r_head);
                    n_cur         = r_head;
                    n_cnt         = '0;
                    n_state       = S_INS_WALK;
                end
            end

            S_INS_WALK: begin
                // i_rd_link is the link of r_cur
                if (!is_node(i_rd_link)) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_idx  = to_idx(r_cur);
                    o_req.wr_link = r_slot;
                    n_state       = S_FIN;
                end else if (r_cnt == LAST_STEP) begin
                    // walk bound reached: link from the node that r_cur links to
                    o_req.wr_en   = 1'b1;
                    o_req.wr_idx  = to_idx(i_rd_link);
                    o_req.wr_link = r_slot;
                    n_state       = S_FIN;
                end else begin
                    n_cur        = i_rd_link;
                    n_cnt        = r_cnt + IDX_W'(1);
                    o_req.rd_en  = 1'b1;
                    o_req.rd_idx = to_idx(i_rd_link);
                end
            end

            S_DH: begin
                n_head        = i_rd_link;
                o_req.wr_en   = 1'b1;
                o_req.wr_idx  = to_idx(r_slot);
                o_req.wr_link = r_free;
                n_free        = r_slot;
                n_state       = S_FIN;
            end

            S_DT_FIRST: begin
                if (!is_node(i_rd_link)) begin
                    // single node list
                    n_head        = LINK_NULL;
                    o_req.wr_en   = 1'b1;
                    o_req.wr_idx  = to_idx(r_slot);
                    o_req.wr_link = r_free;
                    n_free        = r_slot;
                    n_state       = S_FIN;
                end else begin
                    n_prev       = r_head;
                    n_cur        = i_rd_link;
                    n_cnt        = '0;
                    o_req.rd_en  = 1'b1;
                    o_req.rd_idx = to_idx(i_rd_link);
                    n_state      = S_DT_WALK;
                end
            end

            S_DT_WALK: begin
                // r_prev links to r_cur, i_rd_link is the link of r_cur
                if (!is_node(i_rd_link)) begin
                    n_slot        = r_cur;
                    o_req.wr_en   = 1'b1;
                    o_req.wr_idx  = to_idx(r_prev);
                    o_req.wr_link = LINK_NULL;
                    n_state       = S_DT_FREE;
                end else if (r_cnt == LAST_STEP) begin
                    n_slot        = i_rd_link;
                    o_req.wr_en   = 1'b1;
                    o_req.wr_idx  = to_idx(r_cur);
                    o_req.wr_link = LINK_NULL;
                    n_state       = S_DT_FREE;
                end else begin
                    n_prev       = r_cur;
                    n_cur        = i_rd_link;
                    n_cnt        = r_cnt + IDX_W'(1);
                    o_req.rd_en  = 1'b1;
                    o_req.rd_idx = to_idx(i_rd_link);
                end
            end

            S_DT_FREE: begin
                o_req.wr_en   = 1'b1;
                o_req.wr_idx  = to_idx(r_slot);
                o_req.wr_link = r_free;
                n_free        = r_slot;
                n_state       = S_FIN;
            end

            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status = r_status;
                    n_out.slot   = (r_status == ST_DONE) ? to_slot(r_slot) : '0;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/cursor_list_with_free_pool_unit.sv
// ----------------------------------------------------------------------------
// cursor_list_with_free_pool_unit: linked list in a node array
// Singly linked list over NODES nodes with a free pool, serving insert and
// delete requests at either end.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in) carries func and value.
//   Result channel (o_out_valid / i_out_stall / o_out) returns status and
//   slot, one result per request, in request order.
//   A transfer happens on a rising edge with valid high and stall low.
//   o_in_stall is high while a request is being worked on.
//   To the result: a full or empty answer goes straight to the final state;
//   head insert, head delete, insert into an empty list and tail delete of
//   a single node first take one node store read and write; tail insert
//   and other tail deletes first walk from the head to the tail, one list
//   link at a time through the single registered read port of the node
//   link store. o_in_stall drops in the same cycle as the result is
//   registered, so no request transfers before the last one's result is.
//   The result register lets a new request transfer while the last result
//   is still stalled; the sequencer then holds in its final state until
//   the result register frees up.
//   Reset (synchronous, active low) empties the list and puts every node in
//   the free pool; stored elements stay undefined until written.
// ----------------------------------------------------------------------------
module cursor_list_with_free_pool_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  clwf_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output clwf_pkg::t_out o_out
);
    import clwf_pkg::*;

    t_mem_req          mem_req;
    logic [LINK_W-1:0] rd_link;

    clwf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_req       (mem_req),
        .i_rd_link   (rd_link)
    );

    clwf_node_ram u_node_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_link (rd_link)
    );

endmodule

>>> dv/tb_cursor_list_with_free_pool_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cursor_list_with_free_pool_unit: request/result checker for the list unit
// Runs directed and random head/tail insert and delete requests. The result
// stall pattern and the gaps between requests vary. A scoreboard keeps its
// own copy of the node links, the list head and the free pool, and checks
// status and slot of each result in request order.
// ----------------------------------------------------------------------------
module tb_cursor_list_with_free_pool_unit;
    import clwf_pkg::*;

    localparam int RANDOM_ITEMS = 1425;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 40;

    // mirror of the node links, free pool and list head; one answer per request
    class cursor_list_checker;
        logic [LINK_W-1:0] link_of [NODES];
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] free_top;
        t_out              pending [$];
        int unsigned       errors;
        int unsigned       requests;
        int unsigned       by_status [3];

        function new();
            for (int i = 0; i < NODES; i++) begin
                link_of[i] = (i == 0) ? LINK_NULL : LINK_W'(i - 1);
            end
            head     = LINK_NULL;
            free_top = LINK_W'(NODES - 1);
            errors   = 0;
            requests = 0;
            for (int i = 0; i < 3; i++) by_status[i] = 0;
        endfunction

        function t_out answer(input t_in r);
            t_out              a;
            logic [LINK_W-1:0] n;
            logic [LINK_W-1:0] cur;
            logic [LINK_W-1:0] prev;
            int                s;
            a.status = ST_DONE;
            a.slot   = '0;
            n        = LINK_NULL;
            case (r.func)
                F_INS_HEAD, F_INS_TAIL: begin
                    if (free_top >= LINK_NULL) begin
                        a.status = ST_FULL;
                    end else begin
                        n        = free_top;
                        free_top = link_of[n];
                        a.slot   = n[SLOT_W-1:0];
                        if (r.func == F_INS_HEAD || head >= LINK_NULL) begin
                            link_of[n] = (r.func == F_INS_HEAD) ? head : LINK_NULL;
                            head       = n;
                        end else begin
                            link_of[n] = LINK_NULL;
                            cur        = head;
                            for (s = 0; s < NODES; s++) begin
                                if (link_of[cur] >= LINK_NULL) break;
                                cur = link_of[cur];
                            end
                            link_of[cur] = n;
                        end
                    end
                end
                default: begin
                    if (head >= LINK_NULL) begin
                        a.status = ST_EMPTY;
                    end else begin
                        if (r.func == F_DEL_HEAD) begin
                            n    = head;
                            head = link_of[n];
                        end else if (link_of[head] >= LINK_NULL) begin
                            // single node: tail is the head
                            n    = head;
                            head = LINK_NULL;
                        end else begin
                            prev = head;
                            n    = link_of[head];
                            for (s = 0; s < NODES; s++) begin
                                if (link_of[n] >= LINK_NULL) break;
                                prev = n;
                                n    = link_of[n];
                            end
                            link_of[prev] = LINK_NULL;
                        end
                        link_of[n] = free_top;
                        free_top   = n;
                        a.slot     = n[SLOT_W-1:0];
                    end
                end
            endcase
            return a;
        endfunction

        function void note_request(input t_in r);
            pending.push_back(answer(r));
            requests++;
        endfunction

        function void check_result(input t_out got);
            t_out exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d",
                         $time, got.status, got.slot);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, exp.status, got.status);
                errors++;
            end
            if (got.slot !== exp.slot) begin
                $display("%0t: slot mismatch, expected %0d, got %0d",
                         $time, exp.slot, got.slot);
                errors++;
            end
            if (exp.status < 3) by_status[exp.status]++;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    cursor_list_checker board = new();

    bit          long_hold_req = 1'b0;
    int unsigned quiet_cycles  = 0;

    cursor_list_with_free_pool_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) board.note_request(i_in);
            if (o_out_valid && !i_out_stall) board.check_result(o_out);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles == QUIET_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                    $display("FAIL cursor_list_with_free_pool_unit");
                    $finish;
                end
            end
        end
    end

    // result side stall pattern, with one long hold-off on request
    initial begin
        int unsigned mode_left;
        int unsigned mode;
        int unsigned hold_left;
        mode_left   = 0;
        mode        = 0;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                mode      = $urandom_range(0, 3);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    task automatic send_op(input t_func f, input logic [VAL_W-1:0] v);
        t_in r;
        r.func  = f;
        r.value = v;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_func pick_func(input int unsigned ins_pct);
        bit at_tail;
        at_tail = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < ins_pct) return at_tail ? F_INS_TAIL : F_INS_HEAD;
        return at_tail ? F_DEL_TAIL : F_DEL_HEAD;
    endfunction

    initial begin
        int unsigned burst_left;
        int unsigned ins_pct;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty deletes, fill to full, full inserts, drain by tail walks
        send_op(F_DEL_HEAD, 32'h0);
        send_op(F_DEL_TAIL, 32'hffff_ffff);
        send_op(F_INS_TAIL, 32'h7fff_ffff);
        send_op(F_INS_HEAD, 32'h8000_0000);
        send_op(F_INS_TAIL, 32'h0000_0000);
        send_op(F_INS_TAIL, 32'hffff_ffff);
        send_op(F_INS_HEAD, 32'h5555_5555);
        send_op(F_INS_TAIL, 32'haaaa_aaaa);
        send_op(F_INS_HEAD, 32'h0000_0001);
        send_op(F_INS_TAIL, 32'hfffe_0000);
        send_op(F_INS_HEAD, 32'h1234_5678);
        send_op(F_INS_TAIL, 32'h8765_4321);
        send_op(F_DEL_TAIL, 32'h0);
        send_op(F_DEL_HEAD, 32'h0);
        send_op(F_INS_TAIL, 32'h0f0f_0f0f);
        repeat (7) send_op(F_DEL_TAIL, $urandom);
        send_op(F_DEL_TAIL, 32'h0);
        send_op(F_INS_HEAD, 32'hf0f0_f0f0);
        send_op(F_DEL_HEAD, 32'h0);

        burst_left = 0;
        ins_pct    = 50;
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 75;
                    1:       ins_pct = 25;
                    default: ins_pct = 50;
                endcase
            end
            if (k == 300) long_hold_req = 1'b1;
            if (k == 700 || k == 1100) begin
                // let every outstanding result drain before going on
                pause_sender(1);
                while (board.pending.size() != 0) @(posedge i_clk);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
            end
            burst_left--;
            send_op(pick_func(ins_pct), pick_value());
        end
        pause_sender(1);

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Ran %0d requests: %0d done, %0d pool full, %0d empty answers.",
                 board.requests, board.by_status[ST_DONE], board.by_status[ST_FULL],
                 board.by_status[ST_EMPTY]);
        $display("Included a long result hold-off and two full drains.");
        if (board.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, board.pending.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("PASS cursor_list_with_free_pool_unit");
        end else begin
            $display("FAIL cursor_list_with_free_pool_unit");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/clwf_pkg.sv
rtl/clwf_node_ram.sv
rtl/clwf_seq.sv
rtl/cursor_list_with_free_pool_unit.sv
dv/tb_cursor_list_with_free_pool_unit.sv
